// ===== rtl/gsp_pkg.sv =====
// Shared types and constants for the gripper stepper position driver.
// No dependencies; imported by the result and cfg interfaces, the top level and its checker.
package gsp_pkg;

  // Item kinds carried on the input channel
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_OPEN    = 2'd1,
    FUNC_CLOSE   = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TICK_INTERVAL = 2'd0,
    REG_OPEN_STEPS    = 2'd1,
    REG_CLOSE_STEPS   = 2'd2,
    REG_RELEASE_STEPS = 2'd3
  } reg_idx_t;

  typedef logic [3:0] coils_t;

  // Reset values of the configuration registers
  localparam logic        [7:0]  TICK_INTERVAL_RST = 8'd2;
  localparam logic signed [15:0] OPEN_STEPS_RST    = -16'sd900;
  localparam logic signed [15:0] CLOSE_STEPS_RST   = 16'sd1400;
  localparam logic signed [15:0] RELEASE_STEPS_RST = 16'sd100;

  // All coils released
  localparam coils_t COILS_OFF = 4'b0000;

  // Full-step two-phase pattern for each phase, first coil in bit 3
  function automatic coils_t phase_coils(input logic [1:0] phase);
    coils_t pattern;
    case (phase)
      2'd0:    pattern = 4'b0011;
      2'd1:    pattern = 4'b0110;
      2'd2:    pattern = 4'b1100;
      2'd3:    pattern = 4'b1001;
      default: pattern = COILS_OFF;
    endcase
    return pattern;
  endfunction

endpackage

// ===== rtl/gsp_item_if.sv =====
// Input channel of the gripper stepper driver: tick or command items.
// No dependencies.
interface gsp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;

  modport source (output valid, output func, output now_ms, input ready);
  modport sink   (input valid, input func, input now_ms, output ready);
endinterface

// ===== rtl/gsp_result_if.sv =====
// Result channel of the gripper stepper driver: coil drive and position status.
// Depends on gsp_pkg for the coil pattern type.
interface gsp_result_if;
  import gsp_pkg::*;
  logic               valid;
  logic               ready;
  coils_t             coils;
  logic               coils_update;
  logic signed [15:0] position;
  logic               at_target;

  modport source (output valid, output coils, output coils_update, output position,
                  output at_target, input ready);
  modport sink   (input valid, input coils, input coils_update, input position,
                  input at_target, output ready);
endinterface

// ===== rtl/gsp_cfg_if.sv =====
// Configuration write channel of the gripper stepper driver.
// Register index and write data; depends on gsp_pkg for the index type.
interface gsp_cfg_if;
  import gsp_pkg::*;
  logic        valid;
  logic        ready;
  reg_idx_t    index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gripper_stepper_position_driver.sv =====
// Full-step position controller for a four-coil unipolar gripper stepper.
// Depends on gsp_pkg and the gsp_item_if, gsp_result_if and gsp_cfg_if interfaces.
//
// Usage:
//   item   : valid/ready input. func selects tick (now_ms carries the time) or an
//            open, close or release command.
//   result : valid/ready output, one transfer for every item transfer, in order.
//   cfg    : register writes (tick interval, open/close/release targets); always
//            ready, written at any transfer, meant to change only while idle.
// Result valid rises in the cycle after the item transfer. An item is taken in
// every cycle while the result register is empty or being drained in the same
// cycle, so the sustained rate is one item per clock; the whole step decision
// (time compare, one-step move, phase table) sits between the item transfer and
// the result register.
// When the receiver stalls, the result register holds and item.ready drops
// until that result transfers; no item is lost or dropped.
// Reset (rst, synchronous) empties the result register, zeroes phase, position,
// target and last tick time, marks the gripper closed and loads the register
// defaults (interval 2 ms, open -900, close 1400, release 100 steps).
module gripper_stepper_position_driver #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  gsp_item_if.sink     item,
  gsp_result_if.source result,
  gsp_cfg_if.sink      cfg
);
  import gsp_pkg::*;

  // Configuration registers
  logic        [7:0]  tick_interval;
  logic signed [15:0] open_steps;
  logic signed [15:0] close_steps;
  logic signed [15:0] release_steps;

  // Controller state
  logic        [1:0]                phase;
  logic signed [POSITION_WIDTH-1:0] moved_steps;
  logic signed [POSITION_WIDTH-1:0] goal_steps;
  logic                             is_closed;
  logic        [31:0]               last_tick_time;

  logic        [1:0]                phase_next;
  logic signed [POSITION_WIDTH-1:0] moved_steps_next;
  logic signed [POSITION_WIDTH-1:0] goal_steps_next;
  logic                             is_closed_next;
  logic        [31:0]               last_tick_time_next;
  coils_t                           coils_next;
  logic                             update_next;

  logic        item_xfer;
  logic [31:0] elapsed;
  logic        tick_acts;
  func_t       func;

  // Take a new item whenever the result register is free this cycle
  assign item.ready = !result.valid || result.ready;
  assign item_xfer  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;
  assign func       = func_t'(item.func);

  // Elapsed time wraps modulo 2^32
  assign elapsed   = item.now_ms - last_tick_time;
  assign tick_acts = elapsed >= {24'd0, tick_interval};

  // Step decision for one item
  always_comb begin
    phase_next          = phase;
    moved_steps_next    = moved_steps;
    goal_steps_next     = goal_steps;
    is_closed_next      = is_closed;
    last_tick_time_next = last_tick_time;
    coils_next          = COILS_OFF;
    update_next         = 1'b0;
    case (func)
      FUNC_TICK: begin
        if (tick_acts) begin
          last_tick_time_next = item.now_ms;
          update_next         = 1'b1;
          if (goal_steps > moved_steps) begin
            moved_steps_next = moved_steps + POSITION_WIDTH'(1);
            coils_next       = phase_coils(phase);
            phase_next       = phase + 2'd1;
          end else if (goal_steps < moved_steps) begin
            moved_steps_next = moved_steps - POSITION_WIDTH'(1);
            coils_next       = phase_coils(phase);
            phase_next       = phase - 2'd1;
          end
        end
      end
      FUNC_OPEN: begin
        if (is_closed) begin
          moved_steps_next = '0;
          goal_steps_next  = POSITION_WIDTH'(open_steps);
          is_closed_next   = 1'b0;
        end
      end
      FUNC_CLOSE: begin
        if (!is_closed) begin
          moved_steps_next = '0;
          goal_steps_next  = POSITION_WIDTH'(close_steps);
          is_closed_next   = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        moved_steps_next = '0;
        goal_steps_next  = POSITION_WIDTH'(release_steps);
      end
      default: begin
        moved_steps_next = moved_steps;
      end
    endcase
  end

  // Advance controller state on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      moved_steps    <= '0;
      goal_steps     <= '0;
      is_closed      <= 1'b1;
      last_tick_time <= '0;
    end else if (item_xfer) begin
      phase          <= phase_next;
      moved_steps    <= moved_steps_next;
      goal_steps     <= goal_steps_next;
      is_closed      <= is_closed_next;
      last_tick_time <= last_tick_time_next;
    end
  end

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_interval <= TICK_INTERVAL_RST;
      open_steps    <= OPEN_STEPS_RST;
      close_steps   <= CLOSE_STEPS_RST;
      release_steps <= RELEASE_STEPS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_TICK_INTERVAL: tick_interval <= cfg.data[7:0];
        REG_OPEN_STEPS:    open_steps    <= cfg.data;
        REG_CLOSE_STEPS:   close_steps   <= cfg.data;
        REG_RELEASE_STEPS: release_steps <= cfg.data;
        default:           tick_interval <= tick_interval;
      endcase
    end
  end

  // Result register: hold while stalled, refill on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (item_xfer) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      result.coils        <= coils_next;
      result.coils_update <= update_next;
      result.position     <= 16'(moved_steps_next);
      result.at_target    <= moved_steps_next == goal_steps_next;
    end
  end

endmodule

// ===== rtl/gsp_checker.sv =====
// Port-level checks for the gripper stepper driver, bound to its top level.
// Depends on gsp_pkg for item kinds and the off pattern.
module gsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic [1:0]  item_func,
  input logic        result_valid,
  input logic [3:0]  result_coils,
  input logic        result_coils_update,
  input logic [15:0] result_position,
  input logic        result_at_target
);
  import gsp_pkg::*;

  logic item_xfer;
  assign item_xfer = item_valid && item_ready;

  // Every item transfer yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst) item_xfer |=> result_valid)
    else $error("gsp: no result after item transfer");

  // Commands never drive the coils
  assert property (@(posedge clk) disable iff (rst)
    item_xfer && item_func != FUNC_TICK |=> !result_coils_update)
    else $error("gsp: command drove coils");

  // Release always zeroes the position
  assert property (@(posedge clk) disable iff (rst)
    item_xfer && item_func == FUNC_RELEASE |=> result_position == 16'd0)
    else $error("gsp: release left nonzero position");

  // Undriven results carry the off pattern
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_coils_update |-> result_coils == COILS_OFF)
    else $error("gsp: coils set without update");

  // An acting tick that releases the coils is one at the target
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_coils_update && result_coils == COILS_OFF
      |-> result_at_target)
    else $error("gsp: coils off while away from target");

endmodule

bind gripper_stepper_position_driver gsp_checker u_gsp_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_valid          (item.valid),
  .item_ready          (item.ready),
  .item_func           (item.func),
  .result_valid        (result.valid),
  .result_coils        (result.coils),
  .result_coils_update (result.coils_update),
  .result_position     (result.position),
  .result_at_target    (result.at_target)
);
